// ----- src/mse_pkg.sv -----
package mse_pkg;

  // operand kinds
  localparam logic [1:0] OP_REG_DIRECT = 2'd0;
  localparam logic [1:0] OP_RIP_DIRECT = 2'd1;
  localparam logic [1:0] OP_MEMORY     = 2'd2;
  localparam logic [1:0] OP_IMMEDIATE  = 2'd3;

  // displacement length codes
  localparam logic [1:0] DISP_NONE = 2'd0;
  localparam logic [1:0] DISP_BYTE = 2'd1;
  localparam logic [1:0] DISP_WORD = 2'd2;

  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_DISP32   = 3'd5;
  localparam logic [2:0] SIB_NO_IDX  = 3'd4;
  localparam logic [2:0] SIB_NO_BASE = 3'd5;
  localparam logic [1:0] MOD_NODISP  = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP32  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         reg_bits;
    logic [2:0]         base_number;
    logic               base_present;
    logic [2:0]         index_number;
    logic               index_present;
    logic [3:0]         scale_factor;
    logic signed [31:0] displacement;
    logic               disp_present;
  } mse_in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       error;
  } mse_out_t;

  // classified request held between front and back
  typedef struct packed {
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic        has_sib;
    logic [1:0]  disp_size;
    logic [31:0] disp;
    logic        err;
  } mse_desc_t;

endpackage

// ----- src/mse_front.sv -----
module mse_front (
  input  mse_pkg::mse_in_t   req,
  output mse_pkg::mse_desc_t desc
);
  import mse_pkg::*;

  logic        sib_need;
  logic        scale_ok;
  logic [1:0]  sbits;
  logic [1:0]  mod;
  logic [2:0]  rm;
  logic [31:0] d;
  logic        fits8;

  always_comb begin
    d = req.disp_present ? req.displacement : 32'd0;
    fits8 = (d[31:7] == 25'd0) || (d[31:7] == {25{1'b1}});
    sib_need = req.index_present || (req.base_number == RM_SIB);
    rm = sib_need ? RM_SIB : req.base_number;
    scale_ok = 1'b1;
    unique case (req.scale_factor)
      4'd1: sbits = 2'd0;
      4'd2: sbits = 2'd1;
      4'd4: sbits = 2'd2;
      4'd8: sbits = 2'd3;
      default: begin
        sbits = 2'd0;
        scale_ok = 1'b0;
      end
    endcase
    priority if (!req.base_present) begin
      mod = MOD_NODISP;
    end else if (!req.disp_present) begin
      mod = (req.base_number == RM_DISP32) ? MOD_DISP8 : MOD_NODISP;
    end else if (fits8) begin
      mod = MOD_DISP8;
    end else begin
      mod = MOD_DISP32;
    end

    desc = '0;
    unique case (req.op)
      OP_REG_DIRECT: begin
        desc.modrm = {MOD_REG, req.reg_bits, req.base_number};
      end
      OP_RIP_DIRECT: begin
        desc.modrm     = {MOD_NODISP, req.reg_bits, RM_DISP32};
        desc.disp      = req.displacement;
        desc.disp_size = DISP_WORD;
      end
      OP_MEMORY: begin
        if ((!req.base_present && !req.index_present) || (sib_need && !scale_ok)) begin
          desc.err = 1'b1;
        end else begin
          desc.modrm   = {mod, req.reg_bits, rm};
          desc.has_sib = sib_need;
          desc.sib     = {sbits,
                          req.index_present ? req.index_number : SIB_NO_IDX,
                          req.base_present ? req.base_number : SIB_NO_BASE};
          desc.disp    = d;
          // index with no base always carries a disp32
          if (!req.base_present || mod == MOD_DISP32) begin
            desc.disp_size = DISP_WORD;
          end else if (mod == MOD_DISP8) begin
            desc.disp_size = DISP_BYTE;
          end else begin
            desc.disp_size = DISP_NONE;
          end
        end
      end
      default: begin
        desc.err = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/mse_queue.sv -----
module mse_queue #(
  parameter int DEPTH = mse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mse_pkg::mse_desc_t push_data,
  input  logic               pop,
  output mse_pkg::mse_desc_t head,
  output logic               empty,
  output logic               full
);
  import mse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mse_desc_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == FULL_CNT);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/mse_back.sv -----
module mse_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mse_pkg::mse_desc_t head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mse_pkg::mse_out_t  out_data
);
  import mse_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic       valid_r, valid_nxt;
  mse_out_t   data_r, data_nxt;
  logic       load;
  logic [2:0] n_bytes;
  logic [1:0] k;
  logic       is_last;
  logic [7:0] disp_byte;

  assign load = !empty && (!valid_r || !out_stall);

  always_comb begin
    unique case (head.disp_size)
      DISP_BYTE: n_bytes = 3'd2 + {2'b0, head.has_sib};
      DISP_WORD: n_bytes = 3'd5 + {2'b0, head.has_sib};
      default:   n_bytes = 3'd1 + {2'b0, head.has_sib};
    endcase
    is_last = (pos_r == n_bytes - 3'd1);
    // displacement byte number, little-endian
    k = 2'(pos_r - 3'd1 - {2'b0, head.has_sib});
    unique case (k)
      2'd0: disp_byte = head.disp[7:0];
      2'd1: disp_byte = head.disp[15:8];
      2'd2: disp_byte = head.disp[23:16];
      default: disp_byte = head.disp[31:24];
    endcase

    data_nxt  = data_r;
    valid_nxt = valid_r && out_stall;
    pos_nxt   = pos_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (head.err) begin
        data_nxt = '{code_byte: 8'd0, last: 1'b1, error: 1'b1};
        pop      = 1'b1;
        pos_nxt  = '0;
      end else begin
        priority if (pos_r == 3'd0) begin
          data_nxt.code_byte = head.modrm;
        end else if (pos_r == 3'd1 && head.has_sib) begin
          data_nxt.code_byte = head.sib;
        end else begin
          data_nxt.code_byte = disp_byte;
        end
        data_nxt.last  = is_last;
        data_nxt.error = 1'b0;
        pop     = is_last;
        pos_nxt = is_last ? 3'd0 : pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- src/modrm_sib_address_encoder.sv -----
// ModR/M and SIB address encoder: each accepted operand request is classified
// on entry and queued, then sent out as its encoding one byte per cycle while
// out_stall is low: ModR/M, optional SIB, then a 0, 1 or 4 byte little-endian
// displacement, with last set on the final byte and a single zero byte with
// error set for an operand that cannot be encoded. An operand's encoding is 1
// to 6 bytes long; the front keeps taking requests while the queue
// (QUEUE_DEPTH entries) has room. A request is first written into the queue,
// and its first byte is then registered in the output stage before it appears.
module modrm_sib_address_encoder #(
  parameter int QUEUE_DEPTH = mse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mse_pkg::mse_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mse_pkg::mse_out_t out_data
);
  import mse_pkg::*;

  mse_desc_t desc;
  mse_desc_t head;
  logic      push;
  logic      pop;
  logic      empty;
  logic      full;

  assign in_stall = full;
  assign push     = in_valid && !full;

  mse_front u_front (
    .req  (in_data),
    .desc (desc)
  );

  mse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  mse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
